[rtl/core/csfs_pkg.sv]
// csfs_pkg: widths, status codes and the divider cell payload type
// for the chi-square feature score block; no dependencies
package csfs_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SCORE_W    = 32;
  localparam int STATUS_W   = 2;

  localparam int PROD_W = 2 * COUNT_BITS;
  localparam int DEN_W  = 4 * COUNT_BITS;
  localparam int P_W    = 5 * COUNT_BITS;
  localparam int NUM_W  = P_W + FRAC_BITS;
  localparam int REM_W  = DEN_W + 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_NORMAL = 2'd0,
    ST_DEGEN  = 2'd1,
    ST_BAD    = 2'd2
  } status_t;

  typedef struct packed {
    logic               valid;
    status_t            status;
    logic               sat;
    logic [REM_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
    logic [SCORE_W-1:0] low;
    logic [SCORE_W-1:0] quo;
  } cell_data_t;

endpackage

[rtl/core/csfs_in_if.sv]
// csfs_in_if: input item channel, valid/ready plus the three counts
// depends on csfs_pkg
interface csfs_in_if;
  import csfs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] joint_count;
  logic [COUNT_BITS-1:0] class_count;
  logic [COUNT_BITS-1:0] feature_count;
  modport source (output valid, joint_count, class_count, feature_count, input ready);
  modport sink (input valid, joint_count, class_count, feature_count, output ready);
endinterface

[rtl/core/csfs_out_if.sv]
// csfs_out_if: result item channel, valid/ready plus score and status
// depends on csfs_pkg
interface csfs_out_if;
  import csfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;
  logic [STATUS_W-1:0] status;
  modport source (output valid, score, status, input ready);
  modport sink (input valid, score, status, output ready);
endinterface

[rtl/core/csfs_front.sv]
// csfs_front: status check and product stages ahead of the divider chain
// depends on csfs_pkg
module csfs_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [csfs_pkg::COUNT_BITS-1:0] a,
  input  logic [csfs_pkg::COUNT_BITS-1:0] g,
  input  logic [csfs_pkg::COUNT_BITS-1:0] c,
  input  logic [csfs_pkg::COUNT_BITS-1:0] n,
  output csfs_pkg::cell_data_t            head
);
  import csfs_pkg::*;

  status_t                st_in;
  logic [COUNT_BITS:0]    cg_sum;
  logic [COUNT_BITS:0]    na_sum;

  logic                   v1, v2, v3, v4;
  status_t                st1, st2, st3, st4;
  logic [PROD_W-1:0]      an1, cg1, nn1;
  logic [COUNT_BITS-1:0]  n1, n2, n3;
  logic [PROD_W-1:0]      x2;
  logic [DEN_W-1:0]       den2, den3, den4, xx3;
  logic [P_W-1:0]         p3;
  logic [NUM_W-1:0]       num4, top4;

  always_comb begin
    cg_sum = {1'b0, c} + {1'b0, g};
    na_sum = {1'b0, n} + {1'b0, a};
    if (c == '0 || g == '0 || c == n || g == n) begin
      st_in = ST_DEGEN;
    end else if (c > n || g > n || a > c || a > g || cg_sum > na_sum) begin
      st_in = ST_BAD;
    end else begin
      st_in = ST_NORMAL;
    end
  end

  assign p3   = P_W'(xx3) * P_W'(n3);
  assign top4 = num4 >> SCORE_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      head.valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      head.valid <= v4;
    end
    if (en) begin
      st1  <= st_in;
      an1  <= PROD_W'(a) * PROD_W'(n);
      cg1  <= PROD_W'(c) * PROD_W'(g);
      nn1  <= PROD_W'(n - c) * PROD_W'(n - g);
      n1   <= n;
      st2  <= st1;
      x2   <= (an1 >= cg1) ? an1 - cg1 : cg1 - an1;
      den2 <= DEN_W'(cg1) * DEN_W'(nn1);
      n2   <= n1;
      st3  <= st2;
      xx3  <= DEN_W'(x2) * DEN_W'(x2);
      den3 <= den2;
      n3   <= n2;
      st4  <= st3;
      num4 <= NUM_W'(p3) << FRAC_BITS;
      den4 <= den3;
      head.status <= st4;
      head.sat    <= top4 >= NUM_W'(den4);
      head.rem    <= top4[REM_W-1:0];
      head.den    <= den4;
      head.low    <= num4[SCORE_W-1:0];
      head.quo    <= '0;
    end
  end
endmodule

[rtl/core/csfs_cell.sv]
// csfs_cell: one restoring divide step, one quotient bit per cell
// depends on csfs_pkg
module csfs_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  csfs_pkg::cell_data_t d_in,
  output csfs_pkg::cell_data_t d_out
);
  import csfs_pkg::*;

  logic [REM_W-1:0] trial;
  logic             ge;

  assign trial = {d_in.rem[REM_W-2:0], d_in.low[SCORE_W-1]};
  assign ge    = trial >= REM_W'(d_in.den);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out.valid <= d_in.valid;
    end
    if (en) begin
      d_out.status <= d_in.status;
      d_out.sat    <= d_in.sat;
      d_out.rem    <= ge ? trial - REM_W'(d_in.den) : trial;
      d_out.den    <= d_in.den;
      d_out.low    <= d_in.low << 1;
      d_out.quo    <= {d_in.quo[SCORE_W-2:0], ge};
    end
  end
endmodule

[rtl/core/chi_square_feature_score.sv]
// chi_square_feature_score: top level, product front end and divider cell row
// depends on csfs_pkg, csfs_in_if, csfs_out_if, csfs_front, csfs_cell
//
// channel       dir  payload
// item_in       in   joint_count, class_count, feature_count
// result_out    out  score, status
// sample_count  cfg  sample_count_wdata when sample_count_we
//
// one item per cycle while result_out is not stalled; 5 front stages plus 32 divider cells
// the row of 32 restoring divide cells yields one quotient bit each
// synchronous reset clears all valid bits and sets sample_count to 1
// a stall on result_out freezes the whole pipeline and drops item_in.ready
module chi_square_feature_score (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_count_we,
  input  logic [csfs_pkg::COUNT_BITS-1:0] sample_count_wdata,
  csfs_in_if.sink                         item_in,
  csfs_out_if.source                      result_out
);
  import csfs_pkg::*;

  logic [COUNT_BITS-1:0] sample_count;
  logic                  en;
  cell_data_t            chain [0:SCORE_W];
  cell_data_t            last;

  assign en            = !result_out.valid || result_out.ready;
  assign item_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= COUNT_BITS'(1);
    end else if (sample_count_we) begin
      sample_count <= sample_count_wdata;
    end
  end

  csfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (item_in.valid),
    .a        (item_in.joint_count),
    .g        (item_in.class_count),
    .c        (item_in.feature_count),
    .n        (sample_count),
    .head     (chain[0])
  );

  for (genvar i = 0; i < SCORE_W; i++) begin : g_cell
    csfs_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  assign last              = chain[SCORE_W];
  assign result_out.valid  = last.valid;
  assign result_out.status = last.status;
  assign result_out.score  = (last.status != ST_NORMAL) ? '0 :
                             last.sat ? '1 : last.quo;

`ifndef ASSERT_OFF
  a_ready_rule : assert property (@(posedge clk) disable iff (rst)
    item_in.ready == (!result_out.valid || result_out.ready))
    else $error("ready does not follow output stall");
  a_zero_score : assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.status != ST_NORMAL |-> result_out.score == '0)
    else $error("flagged item with nonzero score");
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.ready |=> result_out.valid)
    else $error("pending result lost");
  a_sat_score : assert property (@(posedge clk) disable iff (rst)
    result_out.valid && last.sat && result_out.status == ST_NORMAL |->
    result_out.score == '1)
    else $error("saturated score not all ones");
`endif
endmodule

[verif/tb_chi_square_feature_score.sv]
// tb_chi_square_feature_score: self-checking bench for the chi-square feature score block
// depends on csfs_pkg, csfs_in_if, csfs_out_if and chi_square_feature_score
`timescale 1ns / 1ps
module tb_chi_square_feature_score;
  import csfs_pkg::*;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    status_t            status;
  } chi_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_count_we = 1'b0;
  logic [COUNT_BITS-1:0] sample_count_wdata = '0;

  csfs_in_if  item_in ();
  csfs_out_if result_out ();

  chi_square_feature_score dut (
    .clk(clk), .rst(rst),
    .sample_count_we(sample_count_we), .sample_count_wdata(sample_count_wdata),
    .item_in(item_in.sink), .result_out(result_out.source)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic [COUNT_BITS-1:0] total_n;
  chi_result_t pending_scores[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int stall_mode = 0;
  logic [ST_BAD:0] status_seen = '0;

  function automatic chi_result_t chi_predict(logic [15:0] a, logic [15:0] g,
                                              logic [15:0] c, logic [15:0] n);
    chi_result_t r;
    logic [31:0] an, cg, x;
    logic [127:0] num, den, q;
    r.score = '0;
    if (c == 0 || g == 0 || c == n || g == n) begin
      r.status = ST_DEGEN;
      return r;
    end
    if (c > n || g > n || a > c || a > g || 17'(c) + 17'(g) - 17'(a) > 17'(n)) begin
      r.status = ST_BAD;
      return r;
    end
    an = a * n;
    cg = c * g;
    x = (an >= cg) ? an - cg : cg - an;
    num = (128'(x) * 128'(x) * 128'(n)) << FRAC_BITS;
    den = 128'(c) * 128'(g) * 128'(n - c) * 128'(n - g);
    q = num / den;
    r.score = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    r.status = ST_NORMAL;
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    chi_result_t exp_r;
    if (!rst && result_out.valid && result_out.ready) begin
      results_seen <= results_seen + 1;
      if (pending_scores.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected item score=%h", result_out.score);
      end else begin
        exp_r = pending_scores.pop_front();
        status_seen[exp_r.status] <= 1'b1;
        if (result_out.score !== exp_r.score || result_out.status !== exp_r.status) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp score=%h status=%0d got score=%h status=%0d",
                     exp_r.score, exp_r.status, result_out.score, result_out.status);
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    case (stall_mode)
      0: result_out.ready <= 1'b1;
      1: result_out.ready <= ($urandom_range(0, 3) != 0);
      2: result_out.ready <= ((cycle_count % 7) < 3);
      default: result_out.ready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  initial begin
    item_in.valid = 1'b0;
    item_in.joint_count = '0;
    item_in.class_count = '0;
    item_in.feature_count = '0;
  end

  task automatic send_cell(logic [15:0] a, logic [15:0] g, logic [15:0] c);
    if (burst_left == 0) begin
      item_in.valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    item_in.valid <= 1'b1;
    item_in.joint_count <= a;
    item_in.class_count <= g;
    item_in.feature_count <= c;
    pending_scores.push_back(chi_predict(a, g, c, total_n));
    @(posedge clk);
    while (!item_in.ready) @(posedge clk);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain_pipeline();
    item_in.valid <= 1'b0;
    burst_left = 0;
    while (pending_scores.size() != 0) @(negedge clk);
    repeat (45) @(negedge clk);
  endtask

  task automatic set_sample_count(logic [15:0] n);
    drain_pipeline();
    sample_count_we <= 1'b1;
    sample_count_wdata <= n;
    @(negedge clk);
    sample_count_we <= 1'b0;
    total_n = n;
  endtask

  task automatic send_valid_table();
    logic [15:0] a, g, c, lo;
    c = 16'($urandom_range(0, total_n));
    g = 16'($urandom_range(0, total_n));
    lo = (17'(c) + 17'(g) > 17'(total_n)) ? 16'(c + g - total_n) : 16'd0;
    a = 16'($urandom_range(lo, (c < g) ? c : g));
    send_cell(a, g, c);
  endtask

  task automatic test_reset_default();
    send_cell(0, 1, 1);
    send_cell(1, 1, 1);
    send_cell(0, 0, 0);
  endtask

  task automatic test_directed();
    set_sample_count(16'd100);
    send_cell(10, 20, 30);
    send_cell(20, 20, 20);
    send_cell(0, 50, 50);
    send_cell(50, 50, 50);
    send_cell(0, 0, 30);
    send_cell(5, 100, 30);
    send_cell(31, 40, 30);
    send_cell(0, 101, 30);
    send_cell(5, 60, 60);
    send_cell(16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_sample_count(16'hFFFF);
    send_cell(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_cell(16'h0001, 16'hFFFE, 16'h0001);
    send_cell(16'h0000, 16'h8000, 16'h7FFF);
    send_cell(16'hFFFE, 16'hFFFE, 16'hFFFE);
    send_cell(16'h1234, 16'hFFFF, 16'h5555);
    set_sample_count(16'd0);
    send_cell(0, 0, 0);
    send_cell(0, 1, 1);
    set_sample_count(16'd2);
    send_cell(1, 1, 1);
    send_cell(0, 1, 1);
  endtask

  task automatic test_random();
    logic [15:0] ns[5] = '{16'd3, 16'd200, 16'd5000, 16'hFFFF, 16'd1};
    for (int p = 0; p < 5; p++) begin
      stall_mode = p % 4;
      set_sample_count((p == 2) ? 16'($urandom_range(2, 65535)) : ns[p]);
      for (int i = 0; i < 140; i++) begin
        if ($urandom_range(0, 9) < 8) send_valid_table();
        else send_cell(16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    total_n = 16'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_default();
    test_directed();
    test_random();
    drain_pipeline();
    $display("sent %0d cells, checked %0d scores across several sample totals",
             items_sent, results_seen);
    $display("status codes observed mask %b", status_seen);
    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
